@@ hdl/dceq_pkg.sv @@
// ----------------------------------------------------------------------------
// dceq_pkg
// Shared types and codes for the dedup compacting event queue.
// ----------------------------------------------------------------------------
package dceq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ID_W    = 6;
    localparam int ARG_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic [ID_W-1:0]         entry_id;
        logic signed [ARG_W-1:0] entry_arg;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic [COUNT_W-1:0]      removed_count;
        logic [COUNT_W-1:0]      occupancy;
        logic                    head_valid;
        logic [ID_W-1:0]         head_id;
        logic signed [ARG_W-1:0] head_arg;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [ARG_W-1:0] arg;
    } t_entry;

endpackage

@@ hdl/dedup_compacting_event_queue.sv @@
// Flow: an item is taken while idle, the list is scanned from memory, and the result is
// then registered at the output (an insert that meets its id early stops its scan there).
// The input stalls from the transfer until the result leaves the sequencer, so a new item
// waits for the one-entry-per-cycle scan of the memory to finish.
// Reset: synchronous active-low i_rst_n empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
// dedup_compacting_event_queue
// Ordered (id, argument) list: insert rejects a duplicate id, release compacts the list.
// ----------------------------------------------------------------------------
module dedup_compacting_event_queue #(
    parameter int QUEUE_DEPTH = dceq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dceq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dceq_pkg::t_out o_out_data
);

    logic           res_valid;
    logic           res_ready;
    dceq_pkg::t_out res_data;

    logic           r_out_valid;
    dceq_pkg::t_out r_out_data;

    dceq_seq #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_ready (res_ready)
    );

    // output register frees when its transfer completes
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/dceq_mem.sv @@
// ----------------------------------------------------------------------------
// dceq_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dceq_mem #(
    parameter int QUEUE_DEPTH = dceq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  dceq_pkg::t_entry               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output dceq_pkg::t_entry               o_rdata
);

    dceq_pkg::t_entry r_mem [QUEUE_DEPTH];
    dceq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dceq_seq.sv @@
// ----------------------------------------------------------------------------
// dceq_seq
// Scan sequencer: walks the packed list one entry per cycle through a single
// compare unit, compacting on release and appending on insert.
// ----------------------------------------------------------------------------
module dceq_seq #(
    parameter int QUEUE_DEPTH = dceq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  dceq_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_res_valid,
    output dceq_pkg::t_out o_res_data,
    input  logic           i_res_ready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + dceq_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_op;
    logic [dceq_pkg::ID_W-1:0]         r_id;
    logic signed [dceq_pkg::ARG_W-1:0] r_arg;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_removed, n_removed;
    logic             r_pend, n_pend;
    logic             r_found, n_found;
    dceq_pkg::t_entry r_head, n_head;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    dceq_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    dceq_pkg::t_entry mem_rdata;

    logic             hit_id;
    logic             hit_all;
    logic             scan_done;
    logic             ins_ok;
    logic [1:0]       status;
    logic [CW-1:0]    occ_after;
    dceq_pkg::t_entry head_after;
    dceq_pkg::t_entry new_entry;
    logic [XW-1:0]    occ_ext;
    logic [XW-1:0]    rem_ext;

    dceq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared compare unit
    assign hit_id    = r_pend && (mem_rdata.id == r_id);
    assign hit_all   = hit_id && (mem_rdata.arg == r_arg);
    assign scan_done = !r_pend && ((r_rd == r_occ) || r_found);

    assign new_entry.id  = r_id;
    assign new_entry.arg = r_arg;

    assign ins_ok = (r_op == dceq_pkg::OP_INSERT) && !r_found && (r_occ != FULL_CNT);

    always_comb begin
        if (r_op == dceq_pkg::OP_RELEASE) begin
            status = dceq_pkg::ST_DONE;
        end else if (r_found) begin
            status = dceq_pkg::ST_DUP;
        end else if (r_occ == FULL_CNT) begin
            status = dceq_pkg::ST_FULL;
        end else begin
            status = dceq_pkg::ST_DONE;
        end
    end

    always_comb begin
        occ_after  = r_occ;
        head_after = r_head;
        if (r_op == dceq_pkg::OP_RELEASE) begin
            occ_after = r_wr;
        end else if (ins_ok) begin
            occ_after = r_occ + CW'(1);
            if (r_occ == '0) begin
                head_after = new_entry;
            end
        end
    end

    assign occ_ext = XW'(occ_after);
    assign rem_ext = XW'(r_removed);

    always_comb begin
        o_res_data.status        = status;
        o_res_data.removed_count = rem_ext[dceq_pkg::COUNT_W-1:0];
        o_res_data.occupancy     = occ_ext[dceq_pkg::COUNT_W-1:0];
        o_res_data.head_valid    = (occ_after != '0);
        o_res_data.head_id       = (occ_after != '0) ? head_after.id : '0;
        o_res_data.head_arg      = (occ_after != '0) ? head_after.arg : '0;
    end

    assign o_res_valid = (r_state == S_FINISH);
    assign o_in_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_removed = r_removed;
        n_pend    = 1'b0;
        n_found   = r_found;
        n_head    = r_head;
        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_rd[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state   = S_SCAN;
                    n_rd      = '0;
                    n_wr      = '0;
                    n_removed = '0;
                    n_found   = 1'b0;
                end
            end
            S_SCAN: begin
                if ((r_rd != r_occ) && !r_found) begin
                    mem_re = 1'b1;
                    n_rd   = r_rd + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_op == dceq_pkg::OP_INSERT) begin
                    n_found = r_found | hit_id;
                end else if (r_pend) begin
                    if (hit_all) begin
                        n_removed = r_removed + CW'(1);
                    end else begin
                        mem_we = 1'b1;
                        n_wr   = r_wr + CW'(1);
                        if (r_wr == '0) begin
                            n_head = mem_rdata;
                        end
                    end
                end
                if (scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                    n_occ   = occ_after;
                    n_head  = head_after;
                    if (ins_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_occ[AW-1:0];
                        mem_wdata = new_entry;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_removed <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_rd      <= n_rd;
            r_wr      <= n_wr;
            r_removed <= n_removed;
            r_pend    <= n_pend;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_in_data.operation;
            r_id  <= i_in_data.entry_id;
            r_arg <= i_in_data.entry_arg;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_CNT)
        else $error("occupancy beyond depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_rd) && (r_rd <= r_occ))
        else $error("compaction write index passed read index");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && ins_ok) |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("insert did not grow list");

    a_release_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && r_op == dceq_pkg::OP_RELEASE)
        |=> (r_occ == $past(r_occ) - $past(r_removed)))
        else $error("release count mismatch");

endmodule
